/* rtl/lpf_pkg.sv */
// lex parse factorizer: shared types and constants
// controller command and status structs, field widths, op, register and direction codes
// no dependencies
`default_nettype none

package lpf_pkg;

	localparam int BYTE_W  = 8;
	localparam int ENTRY_W = 12;
	localparam int LEN_W   = 13;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// input op codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FACTOR = 1'b1;

	// register index taken from paddr[2]
	localparam logic REG_DIRECTION = 1'b0;

	// neighbour direction codes
	localparam logic DIR_PREV = 1'b0;
	localparam logic DIR_NEXT = 1'b1;

	typedef struct packed {
		logic load;       // write one index, update length
		logic issue;      // read rank and char at parse position
		logic rank;       // read both suffix entries, latch char
		logic cmp_start;  // start extension at the two suffixes
		logic cmp_step;   // one character compare
		logic fin;        // load result register, advance position
	} lpf_cmd_t;

	typedef struct packed {
		logic at_end;     // parse position reached the length
		logic cmp_go;     // neighbour exists and both suffixes in range
		logic match;      // current character pair is equal
		logic next_ok;    // next character pair lies inside the text
	} lpf_status_t;

endpackage

`default_nettype wire

/* rtl/lex_parse_factorizer.sv */
// lex parse factorizer top level: register port, controller and datapath
// uses lpf_pkg, lpf_ctrl, lpf_dpath
//
// usage
//  - input channel (in_valid / in_stall): op 0 loads one index of text, suffix array
//    and inverse suffix array; last_load marks the final index and fixes the length
//  - op 1 asks for the next factor from the current parse position
//  - output channel (out_valid / out_stall): one item per factor request, none per load
//  - loads never stall the input channel and may follow back to back
//  - a taken factor request steps through rank read, suffix read, C character compares
//    and the finish state, which loads the result register; C is 0 without a usable
//    neighbour, else L + 1, or L when the extension runs into the text end
//    (L being the common extension length, one character pair a cycle)
//  - a request at the text end goes straight to the finish state
//  - the next item is taken in the cycle after the result register loads; a new
//    result waits in the finish state while out_stall holds the old one
//  - neighbour_direction sits at address 0 of the register port; write it only
//    while no request is in flight
//  - reset clears length, parse position and direction; the memories hold
//    garbage until loaded and no clearing pass runs
`default_nettype none

module lex_parse_factorizer import lpf_pkg::*; #(
	parameter int TEXT_DEPTH = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// register port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [APB_AW-1:0]  paddr,
	input  wire logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]       prdata,
	output logic                    pready,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               op,
	input  wire logic [BYTE_W-1:0]  text_byte,
	input  wire logic [ENTRY_W-1:0] sa_entry,
	input  wire logic [ENTRY_W-1:0] isa_entry,
	input  wire logic               last_load,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    is_literal,
	output logic [BYTE_W-1:0]       literal_char,
	output logic [ENTRY_W-1:0]      start_pos,
	output logic [ENTRY_W-1:0]      source_pos,
	output logic [LEN_W-1:0]        factor_len,
	output logic                    end_of_text
);

	lpf_cmd_t    cmd;
	lpf_status_t status;
	logic        direction_q;
	logic        reg_idx;

	// register index sits above the byte offset
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_DIRECTION) ? APB_DW'(direction_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_PREV;
		end else if (psel && penable && pwrite && pready &&
			(reg_idx == REG_DIRECTION)) begin
			direction_q <= pwdata[0];
		end
	end

	lpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	lpf_dpath #(
		.TEXT_DEPTH (TEXT_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.direction    (direction_q),
		.text_byte    (text_byte),
		.sa_entry     (sa_entry),
		.isa_entry    (isa_entry),
		.last_load    (last_load),
		.status       (status),
		.is_literal   (is_literal),
		.literal_char (literal_char),
		.start_pos    (start_pos),
		.source_pos   (source_pos),
		.factor_len   (factor_len),
		.end_of_text  (end_of_text)
	);

`ifndef SYNTHESIS
	// loads never hold the input channel
	a_load_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_LOAD) |=> !in_stall)
		else $error("input stalled after a load");

	// a taken factor request makes the block busy in the cycle after
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == OP_FACTOR) |=> in_stall)
		else $error("request taken without going busy");

	// end of text results carry nothing else
	a_end_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_text |-> !is_literal && (factor_len == '0) && (start_pos == '0))
		else $error("end of text result not empty");

	// literals are one character, copies are non empty with no char
	a_factor_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_text |->
			(is_literal && (factor_len == LEN_W'(1)) && (source_pos == '0)) ||
			(!is_literal && (factor_len != '0) && (literal_char == '0)))
		else $error("malformed factor");
`endif

endmodule

`default_nettype wire

/* rtl/lpf_ctrl.sv */
// lex parse factorizer: controller state machine
// sequences loads and factor requests; depends on lpf_pkg
`default_nettype none

module lpf_ctrl import lpf_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        op,
	input  wire logic        out_stall,
	input  wire lpf_status_t status,
	output lpf_cmd_t         cmd,
	output logic             in_stall,
	output logic             out_valid
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RANK,
		S_SUFF,
		S_CMP,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && (state_q == S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd           = '0;
		cmd.load      = accept && (op == OP_LOAD);
		cmd.issue     = accept && (op == OP_FACTOR);
		cmd.rank      = (state_q == S_RANK);
		cmd.cmp_start = (state_q == S_SUFF) && status.cmp_go;
		cmd.cmp_step  = (state_q == S_CMP);
		cmd.fin       = (state_q == S_FIN) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result loads, a stalled one holds, a taken one drops
			out_valid_q <= cmd.fin || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (accept && (op == OP_FACTOR))
						state_q <= status.at_end ? S_FIN : S_RANK;
				end
				S_RANK: state_q <= S_SUFF;
				S_SUFF: state_q <= status.cmp_go ? S_CMP : S_FIN;
				S_CMP: begin
					if (!(status.match && status.next_ok))
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/lpf_dpath.sv */
// lex parse factorizer: datapath with text, suffix and rank memories
// length and parse position counters, extension compare, result register; uses lpf_pkg
`default_nettype none

module lpf_dpath import lpf_pkg::*; #(
	parameter int TEXT_DEPTH = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lpf_cmd_t           cmd,
	input  wire logic               direction,
	input  wire logic [BYTE_W-1:0]  text_byte,
	input  wire logic [ENTRY_W-1:0] sa_entry,
	input  wire logic [ENTRY_W-1:0] isa_entry,
	input  wire logic               last_load,
	output lpf_status_t             status,
	output logic                    is_literal,
	output logic [BYTE_W-1:0]       literal_char,
	output logic [ENTRY_W-1:0]      start_pos,
	output logic [ENTRY_W-1:0]      source_pos,
	output logic [LEN_W-1:0]        factor_len,
	output logic                    end_of_text
);

	localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
	localparam int CW = $clog2(TEXT_DEPTH + 1);
	localparam int WW = (CW > LEN_W) ? CW : LEN_W;

	logic [BYTE_W-1:0]  text_mem [TEXT_DEPTH];
	logic [ENTRY_W-1:0] sa_mem   [TEXT_DEPTH];
	logic [ENTRY_W-1:0] isa_mem  [TEXT_DEPTH];

	logic [CW-1:0]      count_q, pos_q, k_q, pa_q, pb_q;
	logic               sealed_q, has_nb_q;
	logic [ENTRY_W-1:0] isa_rd_q, sa_a_rd_q, sa_b_rd_q, src_q;
	logic [BYTE_W-1:0]  txt_a_rd_q, txt_b_rd_q, char_q;

	logic [CW-1:0]      eff_cnt, pa_nx, pb_nx, len_c;
	logic               wr_en, literal_c, has_nb_c, ab_ok;
	logic [WW-1:0]      n_w, j_w, nb_w, a_w, b_w;
	logic [AW-1:0]      txt_addr_a, txt_addr_b;
	logic [CW:0]        sum_c;

	// load address restarts after a sealed text
	assign eff_cnt = sealed_q ? '0 : count_q;
	assign wr_en   = cmd.load && (eff_cnt < CW'(TEXT_DEPTH));

	assign n_w  = WW'(count_q);
	assign j_w  = WW'(isa_rd_q);
	assign nb_w = (direction == DIR_NEXT) ? (j_w + WW'(1)) : (j_w - WW'(1));
	assign a_w  = WW'(sa_a_rd_q);
	assign b_w  = WW'(sa_b_rd_q);

	assign has_nb_c = (j_w < n_w) &&
		((direction == DIR_NEXT) ? ((j_w + WW'(1)) < n_w) : (j_w != '0));
	assign ab_ok    = (a_w < n_w) && (b_w < n_w);

	assign pa_nx = pa_q + CW'(1);
	assign pb_nx = pb_q + CW'(1);

	always_comb begin
		txt_addr_a = AW'(pos_q);
		txt_addr_b = AW'(pb_nx);
		if (cmd.cmp_start) begin
			txt_addr_a = AW'(a_w);
			txt_addr_b = AW'(b_w);
		end else if (cmd.cmp_step) begin
			txt_addr_a = AW'(pa_nx);
		end
	end

	assign status.at_end  = (pos_q >= count_q);
	assign status.cmp_go  = has_nb_q && ab_ok;
	assign status.match   = (txt_a_rd_q == txt_b_rd_q);
	assign status.next_ok = (pa_nx < count_q) && (pb_nx < count_q);

	assign literal_c = (k_q == '0);
	assign len_c     = literal_c ? CW'(1) : k_q;
	assign sum_c     = (CW+1)'(pos_q) + (CW+1)'(len_c);

	// memories
	always_ff @(posedge clk) begin
		if (wr_en) begin
			text_mem[AW'(eff_cnt)] <= text_byte;
			sa_mem[AW'(eff_cnt)]   <= sa_entry;
			isa_mem[AW'(eff_cnt)]  <= isa_entry;
		end
		txt_a_rd_q <= text_mem[txt_addr_a];
		txt_b_rd_q <= text_mem[txt_addr_b];
		if (cmd.issue)
			isa_rd_q <= isa_mem[AW'(pos_q)];
		sa_a_rd_q  <= sa_mem[AW'(j_w)];
		sa_b_rd_q  <= sa_mem[AW'(nb_w)];
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pos_q    <= '0;
			sealed_q <= 1'b0;
		end else if (cmd.load) begin
			count_q  <= wr_en ? (eff_cnt + CW'(1)) : eff_cnt;
			sealed_q <= last_load;
			pos_q    <= '0;
		end else if (cmd.fin && !status.at_end) begin
			if (sum_c >= (CW+1)'(count_q))
				pos_q <= count_q;
			else
				pos_q <= CW'(sum_c);
		end
	end

	// extension working registers
	always_ff @(posedge clk) begin
		if (cmd.rank) begin
			char_q   <= txt_a_rd_q;
			has_nb_q <= has_nb_c;
			k_q      <= '0;
		end
		if (cmd.cmp_start) begin
			pa_q  <= CW'(a_w);
			pb_q  <= CW'(b_w);
			src_q <= sa_b_rd_q;
		end
		if (cmd.cmp_step && status.match) begin
			k_q  <= k_q + CW'(1);
			pa_q <= pa_nx;
			pb_q <= pb_nx;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			if (status.at_end) begin
				is_literal   <= 1'b0;
				literal_char <= '0;
				start_pos    <= '0;
				source_pos   <= '0;
				factor_len   <= '0;
				end_of_text  <= 1'b1;
			end else begin
				is_literal   <= literal_c;
				literal_char <= literal_c ? char_q : '0;
				start_pos    <= ENTRY_W'(pos_q);
				source_pos   <= literal_c ? '0 : src_q;
				factor_len   <= LEN_W'(len_c);
				end_of_text  <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* sim/tb_lex_parse_factorizer.sv */
// testbench for lex_parse_factorizer: directed and random loads and factor requests
// results checked in order against a lex parse predictor kept inside this module
// depends on lpf_pkg and the lex_parse_factorizer rtl
module tb_lex_parse_factorizer;
	timeunit 1ns;
	timeprecision 1ps;
	import lpf_pkg::*;

	localparam int STORE_DEPTH   = 4096;
	localparam int SETTLE_CYCLES = 16;
	localparam int MAX_REPORTS   = 10;
	localparam int PHASE_ITEMS   = 90;
	// byte addresses of the register port: direction and one unmapped slot
	localparam logic [APB_AW-1:0] DIR_ADDR   = {REG_DIRECTION, 2'b00};
	localparam logic [APB_AW-1:0] SPARE_ADDR = {~REG_DIRECTION, 2'b00};

	// one input item as it crosses the input channel
	typedef struct packed {
		logic               op;
		logic [BYTE_W-1:0]  text_byte;
		logic [ENTRY_W-1:0] sa_entry;
		logic [ENTRY_W-1:0] isa_entry;
		logic               last_load;
	} lex_item_t;

	// one factor as it leaves the output channel
	typedef struct packed {
		logic               is_literal;
		logic [BYTE_W-1:0]  literal_char;
		logic [ENTRY_W-1:0] start_pos;
		logic [ENTRY_W-1:0] source_pos;
		logic [LEN_W-1:0]   factor_len;
		logic               end_of_text;
	} factor_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [APB_AW-1:0]  paddr = '0;
	logic [APB_DW-1:0]  pwdata = '0;
	wire  [APB_DW-1:0]  prdata;
	wire                pready;
	logic               in_valid = 1'b0;
	wire                in_stall;
	logic               op = OP_LOAD;
	logic [BYTE_W-1:0]  text_byte = '0;
	logic [ENTRY_W-1:0] sa_entry = '0;
	logic [ENTRY_W-1:0] isa_entry = '0;
	logic               last_load = 1'b0;
	wire                out_valid;
	logic               out_stall = 1'b0;
	wire                is_literal;
	wire [BYTE_W-1:0]   literal_char;
	wire [ENTRY_W-1:0]  start_pos;
	wire [ENTRY_W-1:0]  source_pos;
	wire [LEN_W-1:0]    factor_len;
	wire                end_of_text;

	// items waiting for the driver, factors waiting for the output channel
	lex_item_t pending_items[$];
	factor_t   expected_factors[$];
	int        items_queued = 0;
	int        mismatches = 0;
	int        idle_pct = 0;
	int        stall_pct = 0;
	logic      item_taken = 1'b0;
	lex_item_t next_item;
	factor_t   got_factor;
	factor_t   want_factor;

	// predictor state: the three stores, length, parse position, seal flag, direction
	logic [BYTE_W-1:0]  text_mem [STORE_DEPTH];
	logic [ENTRY_W-1:0] sa_mem   [STORE_DEPTH];
	logic [ENTRY_W-1:0] rank_mem [STORE_DEPTH];
	int unsigned        text_len = 0;
	int unsigned        parse_pos = 0;
	logic               text_sealed = 1'b0;
	logic               dir_shadow = DIR_PREV;

	// scratch text used to build well-formed suffix arrays
	logic [BYTE_W-1:0]  gen_txt[$];

	lex_parse_factorizer #(.TEXT_DEPTH(STORE_DEPTH)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.text_byte    (text_byte),
		.sa_entry     (sa_entry),
		.isa_entry    (isa_entry),
		.last_load    (last_load),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_literal   (is_literal),
		.literal_char (literal_char),
		.start_pos    (start_pos),
		.source_pos   (source_pos),
		.factor_len   (factor_len),
		.end_of_text  (end_of_text)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// advance the lex parse by one accepted item; a request queues its factor
	task automatic lex_predict(input lex_item_t it);
		factor_t     res;
		int unsigned n, j, nb, a, b, ext, step;
		logic        has_nb;
		res = '0;
		if (it.op == OP_LOAD) begin
			// a load after a sealed text starts a new one
			if (text_sealed) begin
				text_len = 0;
				text_sealed = 1'b0;
			end
			// full store: the load is dropped but last_load still seals
			if (text_len < STORE_DEPTH) begin
				text_mem[text_len] = it.text_byte;
				sa_mem[text_len]   = it.sa_entry;
				rank_mem[text_len] = it.isa_entry;
				text_len++;
			end
			if (it.last_load)
				text_sealed = 1'b1;
			parse_pos = 0;
		end else begin
			n = text_len;
			if (parse_pos >= n) begin
				// at or past the end: flag only, nothing moves
				res.end_of_text = 1'b1;
			end else begin
				j = rank_mem[parse_pos];
				has_nb = 1'b0;
				nb = 0;
				// no neighbour at the array edges or for a rank beyond the length
				if (j < n) begin
					if (dir_shadow == DIR_PREV) begin
						if (j != 0) begin
							nb = j - 1;
							has_nb = 1'b1;
						end
					end else if (j + 1 < n) begin
						nb = j + 1;
						has_nb = 1'b1;
					end
				end
				ext = 0;
				b = 0;
				if (has_nb) begin
					a = sa_mem[j];
					b = sa_mem[nb];
					if (a < n && b < n)
						while (a + ext < n && b + ext < n &&
							text_mem[a + ext] == text_mem[b + ext])
							ext++;
				end
				res.start_pos = ENTRY_W'(parse_pos);
				if (ext == 0) begin
					res.is_literal   = 1'b1;
					res.literal_char = text_mem[parse_pos];
					res.factor_len   = LEN_W'(1);
					step = 1;
				end else begin
					res.source_pos = ENTRY_W'(b);
					res.factor_len = LEN_W'(ext);
					step = ext;
				end
				// bad arrays may claim more than is left: clamp to the end
				if (step >= n - parse_pos)
					parse_pos = n;
				else
					parse_pos += step;
			end
			expected_factors.push_back(res);
		end
	endtask

	// monitor: records input handshakes for the driver, predicts, checks factors
	always @(posedge clk) begin
		if (arst_n) begin
			item_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				got_factor = {is_literal, literal_char, start_pos, source_pos,
					factor_len, end_of_text};
				if (expected_factors.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected factor lit %0d ch %02h st %0d src %0d len %0d end %0d",
							$realtime, is_literal, literal_char, start_pos, source_pos,
							factor_len, end_of_text);
				end else begin
					want_factor = expected_factors.pop_front();
					if (got_factor !== want_factor) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("%0t: factor mismatch", $realtime);
							$display("  expected lit %0d ch %02h start %0d src %0d len %0d end %0d",
								want_factor.is_literal, want_factor.literal_char,
								want_factor.start_pos, want_factor.source_pos,
								want_factor.factor_len, want_factor.end_of_text);
							$display("  actual   lit %0d ch %02h start %0d src %0d len %0d end %0d",
								got_factor.is_literal, got_factor.literal_char,
								got_factor.start_pos, got_factor.source_pos,
								got_factor.factor_len, got_factor.end_of_text);
						end
					end
				end
			end
			// the item seen here was launched at the last falling edge
			if (in_valid && !in_stall)
				lex_predict({op, text_byte, sa_entry, isa_entry, last_load});
		end
	end

	// driver: a new item goes out only once the previous one was taken
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || item_taken) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				next_item = pending_items.pop_front();
				in_valid  <= 1'b1;
				op        <= next_item.op;
				text_byte <= next_item.text_byte;
				sa_entry  <= next_item.sa_entry;
				isa_entry <= next_item.isa_entry;
				last_load <= next_item.last_load;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side back-pressure
	always @(negedge clk) begin
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	task automatic push_item(input logic o, input logic [BYTE_W-1:0] ch,
		input logic [ENTRY_W-1:0] sa, input logic [ENTRY_W-1:0] isa, input logic fin);
		pending_items.push_back({o, ch, sa, isa, fin});
		items_queued++;
	endtask

	// requests carry junk in the load fields, which the block must ignore
	task automatic push_requests(input int count);
		repeat (count)
			push_item(OP_FACTOR, BYTE_W'($urandom), ENTRY_W'($urandom),
				ENTRY_W'($urandom), 1'($urandom));
	endtask

	function automatic logic suffix_less(input int a, input int b);
		int k;
		int n;
		n = gen_txt.size();
		k = 0;
		while (a + k < n && b + k < n) begin
			if (gen_txt[a + k] != gen_txt[b + k])
				return gen_txt[a + k] < gen_txt[b + k];
			k++;
		end
		// the suffix that runs out first is a prefix of the other
		return a + k == n;
	endfunction

	task automatic fill_random_text(input int len, input int alpha);
		logic [BYTE_W-1:0] base;
		base = BYTE_W'($urandom);
		gen_txt.delete();
		repeat (len)
			gen_txt.push_back(alpha == 0 ? BYTE_W'($urandom) :
				BYTE_W'(base + $urandom_range(alpha - 1)));
	endtask

	// loads gen_txt with its true suffix array and ranks, a few entries optionally spoiled
	task automatic queue_loaded_text(input logic seal, input int corrupt_pct);
		int order[$];
		int rank_of[$];
		int len, k, m, tmp;
		logic [ENTRY_W-1:0] sa, isa;
		len = gen_txt.size();
		for (k = 0; k < len; k++)
			order.push_back(k);
		for (k = 1; k < len; k++) begin
			m = k;
			while (m > 0 && suffix_less(order[m], order[m - 1])) begin
				tmp = order[m];
				order[m] = order[m - 1];
				order[m - 1] = tmp;
				m--;
			end
		end
		rank_of = order;
		for (k = 0; k < len; k++)
			rank_of[order[k]] = k;
		for (k = 0; k < len; k++) begin
			sa  = ENTRY_W'(order[k]);
			isa = ENTRY_W'(rank_of[k]);
			if ($urandom_range(99) < corrupt_pct)
				sa = $urandom_range(1) ? ENTRY_W'($urandom) : ENTRY_W'($urandom_range(len));
			if ($urandom_range(99) < corrupt_pct)
				isa = $urandom_range(1) ? ENTRY_W'($urandom) : ENTRY_W'($urandom_range(len));
			push_item(OP_LOAD, gen_txt[k], sa, isa, seal && k == len - 1);
		end
	endtask

	// mostly whole texts parsed to the end, some stray requests and raw noise
	task automatic queue_random_block();
		int kind, len, alpha;
		kind = $urandom_range(99);
		if (kind < 70) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(80, 25) : $urandom_range(24, 1);
			case ($urandom_range(3))
				0: alpha = 1;
				1: alpha = 2;
				2: alpha = 4;
				default: alpha = 0;
			endcase
			fill_random_text(len, alpha);
			queue_loaded_text($urandom_range(9) != 0, ($urandom_range(3) == 0) ? 15 : 0);
			// sometimes cut the parse short so the next load lands mid-text
			push_requests(($urandom_range(4) == 0) ? $urandom_range(len + 2, 1) : len + 2);
		end else if (kind < 85) begin
			push_requests($urandom_range(4, 1));
		end else begin
			repeat ($urandom_range(8, 1))
				push_item(1'($urandom), BYTE_W'($urandom), ENTRY_W'($urandom),
					ENTRY_W'($urandom), $urandom_range(9) == 0);
		end
	endtask

	task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// only the direction register exists, other slots are dropped
		if (addr == DIR_ADDR)
			dir_shadow = data[0];
	endtask

	// wait until every item is taken and every factor is back, then let loads settle
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_factors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int ph, target;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty text, small exact texts, extreme bytes and entries, open text
		write_reg(DIR_ADDR, {31'($urandom), DIR_PREV});
		push_requests(1);
		gen_txt = '{8'h61, 8'h62, 8'h61, 8'h62};
		queue_loaded_text(1'b1, 0);
		push_requests(5);
		gen_txt = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
		queue_loaded_text(1'b1, 0);
		push_requests(4);
		// one-char text whose rank and suffix lie far past the length
		push_item(OP_LOAD, 8'hAA, '1, '1, 1'b1);
		push_requests(2);
		// unsealed text, then a later load appends and rewinds the parse
		gen_txt = '{8'h55, 8'h55, 8'h55};
		queue_loaded_text(1'b0, 0);
		push_requests(2);
		push_item(OP_LOAD, 8'h55, '0, '0, 1'b1);
		push_requests(2);
		drain();

		// unmapped register slot must leave the direction alone
		write_reg(SPARE_ADDR, '1);

		// random phases with the four idling patterns and both directions
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 52; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 52; end
				default: begin idle_pct = 7; stall_pct = 7; end
			endcase
			write_reg(DIR_ADDR, {31'($urandom), ph[0] ? DIR_PREV : DIR_NEXT});
			target = items_queued + PHASE_ITEMS;
			while (items_queued < target)
				queue_random_block();
			drain();
		end

		if (mismatches == 0 && expected_factors.size() == 0)
			$display("tb_lex_parse_factorizer: PASS");
		else
			$display("tb_lex_parse_factorizer: FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("tb_lex_parse_factorizer: FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/lpf_pkg.sv
rtl/lpf_ctrl.sv
rtl/lpf_dpath.sv
rtl/lex_parse_factorizer.sv
sim/tb_lex_parse_factorizer.sv
